/* rtl/nqbs_pkg.sv */
// Package for the N-queens backtracking solver.
// Field widths and compare widths shared by the solver modules and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nqbs_pkg;

  localparam int SIZE_W  = 5;  // board size field
  localparam int ROW_W   = 4;  // row field
  localparam int COL_W   = 4;  // column field
  localparam int CMP_W   = 6;  // headroom for size, row, column and distance compares
  localparam int TDATA_W = 8;  // column + row, byte aligned
  localparam int INDATA_W = 8; // board size, byte aligned

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [CMP_W-1:0] cmp_t;

endpackage

`default_nettype wire

/* rtl/nqbs_conflict_unit.sv */
// Shared attack check: one earlier queen against the candidate queen.
// Depends on nqbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nqbs_conflict_unit (
  input  wire nqbs_pkg::row_t cand_row,
  input  wire nqbs_pkg::row_t prev_row,
  input  wire nqbs_pkg::cmp_t diag_dist,
  output logic                conflict
);
  import nqbs_pkg::*;

  cmp_t r_ext;
  cmp_t p_ext;

  assign r_ext = CMP_W'(cand_row);
  assign p_ext = CMP_W'(prev_row);

  // same row, or either diagonal
  assign conflict = (p_ext == r_ext) || ((p_ext + diag_dist) == r_ext) ||
                    ((r_ext + diag_dist) == p_ext);

endmodule

`default_nettype wire

/* rtl/nqbs_row_stack.sv */
// Row stack: chosen row per column, one write and one registered read per cycle.
// Depends on nqbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nqbs_row_stack #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire                 clk,
  input  wire                 wr_en,
  input  wire [AW-1:0]        wr_addr,
  input  wire nqbs_pkg::row_t wr_data,
  input  wire [AW-1:0]        rd_addr,
  output nqbs_pkg::row_t      rd_data
);
  import nqbs_pkg::*;

  row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/n_queens_backtrack_solver_unit.sv */
// N-queens solver top: sequencer over nqbs_row_stack and nqbs_conflict_unit (nqbs_pkg).
// The search is data dependent; each candidate is checked against every earlier column in turn
//   (shared conflict unit scanning the row stack), and each pop reloads the earlier row.
// One transaction at a time, in_tready high only when idle; each result is read from
//   the row stack, then held until out_tready before the next is read.
// Reset: rst_n synchronous active low; clears sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

module n_queens_backtrack_solver_unit #(
  parameter int MAX_N = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  input  wire [nqbs_pkg::INDATA_W-1:0]  in_tdata,   // [4:0] board_size
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [nqbs_pkg::TDATA_W-1:0]  out_tdata,  // [3:0] column, [7:4] row
  output logic                          out_tuser,  // [0] found
  output logic                          out_tlast
);
  import nqbs_pkg::*;

  localparam int AW       = $clog2(MAX_N);
  localparam int ACCEPT_N = (MAX_N < 16) ? MAX_N : 16;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_ADV     = 3'd2;
  localparam logic [2:0] S_POP     = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;
  localparam logic [2:0] S_WAIT    = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic [AW-1:0]     col_r, col_nxt;
  row_t              cur_row_r, cur_row_nxt;
  logic [AW-1:0]     scan_r, scan_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_last_r, out_last_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  row_t              out_row_r, out_row_nxt;

  logic              st_we;
  logic [AW-1:0]     st_raddr;
  row_t              st_rdata;
  cmp_t              diag_dist;
  logic              conflict;
  logic              scan_more;
  logic              row_inc_ok;
  logic              col_last;
  logic              last_k;
  logic              n_ok;
  logic [SIZE_W-1:0] in_n;

  assign in_n       = in_tdata[SIZE_W-1:0];
  assign n_ok       = (in_n != '0) && (CMP_W'(in_n) <= CMP_W'(ACCEPT_N));
  assign scan_more  = scan_r < col_r;
  assign diag_dist  = CMP_W'(col_r - rd_idx_r);
  assign row_inc_ok = (CMP_W'(cur_row_r) + CMP_W'(1)) < CMP_W'(n_r);
  assign col_last   = (CMP_W'(col_r) + CMP_W'(1)) >= CMP_W'(n_r);
  assign last_k     = (CMP_W'(scan_r) + CMP_W'(1)) == CMP_W'(n_r);
  assign st_raddr   = (state_r == S_ADV) ? (col_r - AW'(1)) : scan_r;

  nqbs_row_stack #(
    .DEPTH (MAX_N),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (col_r),
    .wr_data (cur_row_r),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  nqbs_conflict_unit u_conflict (
    .cand_row  (cur_row_r),
    .prev_row  (st_rdata),
    .diag_dist (diag_dist),
    .conflict  (conflict)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    col_nxt       = col_r;
    cur_row_nxt   = cur_row_r;
    scan_nxt      = scan_r;
    rd_pend_nxt   = rd_pend_r;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    st_we         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt       = in_n;
          col_nxt     = '0;
          cur_row_nxt = '0;
          scan_nxt    = '0;
          rd_pend_nxt = 1'b0;
          found_nxt   = 1'b0;
          state_nxt   = n_ok ? S_SCAN : S_EMIT_LD;
        end
      end
      S_SCAN: begin
        if (rd_pend_r && conflict) begin
          rd_pend_nxt = 1'b0;
          state_nxt   = S_ADV;
        end else if (!scan_more && !rd_pend_r) begin
          st_we = 1'b1;
          if (col_last) begin
            found_nxt = 1'b1;
            scan_nxt  = '0;
            state_nxt = S_EMIT_RD;
          end else begin
            col_nxt     = col_r + AW'(1);
            cur_row_nxt = '0;
            scan_nxt    = '0;
          end
        end else begin
          rd_pend_nxt = scan_more;
          rd_idx_nxt  = scan_r;
          if (scan_more) begin
            scan_nxt = scan_r + AW'(1);
          end
        end
      end
      S_ADV: begin
        if (row_inc_ok) begin
          cur_row_nxt = cur_row_r + ROW_W'(1);
          scan_nxt    = '0;
          rd_pend_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end else if (col_r == '0) begin
          found_nxt = 1'b0;
          state_nxt = S_EMIT_LD;
        end else begin
          col_nxt   = col_r - AW'(1);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cur_row_nxt = st_rdata;
        state_nxt   = S_ADV;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = found_r;
        out_col_nxt   = found_r ? COL_W'(scan_r) : '0;
        out_row_nxt   = found_r ? st_rdata : '0;
        out_last_nxt  = found_r ? last_k : 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            scan_nxt  = scan_r + AW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    col_r       <= col_nxt;
    cur_row_r   <= cur_row_nxt;
    scan_r      <= scan_nxt;
    rd_idx_r    <= rd_idx_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_row_r, out_col_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* rtl/nqbs_checker.sv */
// Port-level checker for the N-queens solver, bound to the top level.
// Depends on nqbs_pkg and n_queens_backtrack_solver_unit.
`timescale 1ns / 1ps
`default_nettype none

module nqbs_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           in_tvalid,
  input wire                           in_tready,
  input wire [nqbs_pkg::INDATA_W-1:0]  in_tdata,
  input wire                           out_tvalid,
  input wire                           out_tready,
  input wire [nqbs_pkg::TDATA_W-1:0]   out_tdata,
  input wire                           out_tuser,
  input wire                           out_tlast
);
  import nqbs_pkg::*;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed under stall");

  // no new transaction taken while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // accepting a transaction closes the input side
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after acceptance");

  // a no-placement result is a single zero result
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("bad no-placement result");

  // the last result returns the block to idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("not idle after last result");

endmodule

bind n_queens_backtrack_solver_unit nqbs_checker u_nqbs_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for n_queens_backtrack_solver_unit: directed and random board sizes.
// A scoreboard class predicts the first N-queens placement per transaction and
// checks each result stream; depends on nqbs_pkg and the solver RTL.
`timescale 1ns / 1ps

typedef struct packed {
  logic       found;
  logic [3:0] column;
  logic [3:0] row;
  logic       last;
} queen_res_t;

class queen_scoreboard;
  queen_res_t      placements_due[$];
  logic [3:0]      row_stack[16];
  int unsigned     errors;

  function new();
    errors = 0;
  endfunction

  function bit column_safe(int col);
    int d;
    for (int c = 0; c < col; c++) begin
      d = col - c;
      if (row_stack[c] == row_stack[col] || row_stack[c] + d == row_stack[col] ||
          row_stack[col] + d == row_stack[c])
        return 0;
    end
    return 1;
  endfunction

  // Runs the search for one board size, queues its results and returns a
  // rough cycle cost of the search.
  function int note_board(logic [4:0] board_size);
    int         n;
    int         col;
    int         work;
    bit         found;
    bit         exhausted;
    queen_res_t res;
    n = int'(board_size);
    col = 0;
    work = 0;
    found = 0;
    exhausted = 0;
    if (n >= 1 && n <= 16) begin
      row_stack[0] = '0;
      while (!found && !exhausted) begin
        work += col + 2;
        if (column_safe(col)) begin
          col++;
          if (col >= n) found = 1;
          else row_stack[col] = '0;
        end else begin
          // next row, popping exhausted columns
          forever begin
            if (row_stack[col] + 1 < n) begin
              row_stack[col] = row_stack[col] + 4'd1;
              break;
            end
            if (col == 0) begin
              exhausted = 1;
              break;
            end
            col--;
            work += 2;
          end
        end
      end
    end
    if (!found) begin
      res = '{found: 1'b0, column: 4'd0, row: 4'd0, last: 1'b1};
      placements_due.push_back(res);
    end else begin
      for (int k = 0; k < n; k++) begin
        res = '{found: 1'b1, column: k[3:0], row: row_stack[k], last: (k + 1 == n)};
        placements_due.push_back(res);
      end
    end
    return work;
  endfunction

  function void report(string what, queen_res_t want, queen_res_t got);
    errors++;
    if (errors <= 10)
      $display("%s: want found=%0d col=%0d row=%0d last=%0d, %s",
               what, want.found, want.column, want.row, want.last,
               $sformatf("got found=%0d col=%0d row=%0d last=%0d",
                         got.found, got.column, got.row, got.last));
  endfunction

  function void check_result(queen_res_t got);
    queen_res_t want;
    if (placements_due.size() == 0) begin
      report("unexpected transaction", '0, got);
      return;
    end
    want = placements_due.pop_front();
    if (got.found !== want.found || got.column !== want.column ||
        got.row !== want.row || got.last !== want.last)
      report("mismatch", want, got);
  endfunction
endclass

module tb;
  import nqbs_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [INDATA_W-1:0] in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [TDATA_W-1:0]  out_tdata;
  logic                out_tuser;
  logic                out_tlast;

  queen_scoreboard sb;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              hold_cycles;
  longint          cycles;
  longint          budget;

  n_queens_backtrack_solver_unit #(.MAX_N(16)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog; budget grows with the predicted search cost of each item
  initial begin
    cycles = 0;
    budget = 20000;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > budget) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        budget += 4 * sb.note_board(in_tdata[SIZE_W-1:0]) + 3000;
      if (out_tvalid && out_tready)
        sb.check_result('{found: out_tuser, column: out_tdata[3:0],
                          row: out_tdata[7:4], last: out_tlast});
    end
  end

  task automatic send_board(input logic [4:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, n};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.placements_due.size() != 0);
  endtask

  function automatic logic [4:0] pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 5'($urandom_range(10, 1));
    if (p < 80) return 5'($urandom_range(13, 11));
    if (p < 82) return 5'($urandom_range(16, 14));
    if (p < 85) return 5'd0;
    return 5'($urandom_range(31, 17));
  endfunction

  initial begin
    logic [4:0] directed[$];
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sizes with and without a placement, zero, oversize, extremes
    directed = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd0,
                 5'd17, 5'd31, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
                 5'd16, 5'd1, 5'd2};
    foreach (directed[i]) send_board(directed[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      // long output hold-off while the sender keeps offering
      if (ph == 0) hold_cycles = 400;
      for (int i = 0; i < 20; i++) send_board(pick_size());
      drain();
    end

    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.placements_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
